/* sv/sensor_event_byte_deframer_unit_macros.svh */
// assertion macros for the sensor event byte deframer
`ifndef SENSOR_EVENT_BYTE_DEFRAMER_UNIT_MACROS_SVH
`define SENSOR_EVENT_BYTE_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SEBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SEBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sebd_pkg.sv */
// shared types, constants and helpers for the sensor event byte deframer
package sebd_pkg;

  typedef logic [2:0] pos_t;
  typedef logic [1:0] mode_t;

  // byte positions within one event
  localparam pos_t POS_ROW   = 3'd0;
  localparam pos_t POS_COL   = 3'd1;
  localparam pos_t POS_STAMP = 3'd2;
  localparam pos_t POS_MAX   = 3'd5;

  // timestamp modes
  localparam mode_t MODE_NONE = 2'd0;
  localparam mode_t MODE_TS16 = 2'd1;
  localparam mode_t MODE_TS24 = 2'd2;
  localparam mode_t MODE_TS32 = 2'd3;

  localparam mode_t MODE_RESET = MODE_TS24;

  typedef struct packed {
    logic [6:0]  pixel_x;
    logic [6:0]  pixel_y;
    logic        polarity;
    logic [31:0] event_time;
  } event_t;

  typedef struct packed {
    logic   fire;
    event_t evt;
  } step_t;

  // number of timestamp bytes for a mode
  function automatic pos_t stamp_bytes(input mode_t mode);
    pos_t n;
    unique case (mode)
      MODE_NONE: n = 3'd0;
      MODE_TS16: n = 3'd2;
      MODE_TS24: n = 3'd3;
      MODE_TS32: n = 3'd4;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

/* sv/sensor_event_byte_deframer_unit.sv */
// top level of the sensor event byte deframer
// Rebuilds address events from a serial event-camera byte stream. Each event
// is a row byte 0yyyyyyy, a byte pxxxxxxx carrying column and polarity, then
// 0, 2, 3 or 4 big-endian timestamp bytes chosen by timestamp_mode (reset 2,
// 24-bit). A row byte with its high bit set is dropped; no other byte is
// checked. One event transaction leaves on the last byte of each event. The
// block takes one byte per clock unless it stalls: a byte is captured in an
// input register, stepped through the framing logic once the result register
// can take it and, on the event's last byte, written into the result register
// at the end of that step. The result register frees itself in the same
// cycle its transaction is taken, so a full stream runs at one byte a
// cycle whenever the consumer does not stall. The mode register is read on
// every byte, so it must only be written while no byte is in flight; the
// mode channel is always ready.
module sensor_event_byte_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  // event channel
  output logic        event_valid,
  input  logic        event_stall,
  output logic [6:0]  pixel_x,
  output logic [6:0]  pixel_y,
  output logic        polarity,
  output logic [31:0] event_time,
  // mode register write channel
  input  logic        mode_valid,
  output logic        mode_ready,
  input  logic [1:0]  timestamp_mode
);
  import sebd_pkg::*;

  `include "sensor_event_byte_deframer_unit_macros.svh"

  mode_t  mode;
  logic   q_valid;
  logic [7:0] q_byte;
  logic   res_free;
  logic   step_en;
  step_t  step;
  pos_t   position;
  event_t held_evt;

  // mode register, written whenever the channel offers data
  assign mode_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (mode_valid && mode_ready) begin
      mode <= timestamp_mode;
    end
  end

  sebd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .data_byte  (data_byte),
    .res_free   (res_free),
    .byte_stall (byte_stall),
    .q_valid    (q_valid),
    .q_byte     (q_byte)
  );

  // a captured byte steps the framer once the result register can take it
  assign step_en = q_valid && res_free;

  sebd_frame_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (step_en),
    .q_byte   (q_byte),
    .mode     (mode),
    .step     (step),
    .position (position)
  );

  sebd_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (step_en && step.fire),
    .evt         (step.evt),
    .event_stall (event_stall),
    .event_valid (event_valid),
    .res_free    (res_free),
    .held_evt    (held_evt)
  );

  assign pixel_x    = held_evt.pixel_x;
  assign pixel_y    = held_evt.pixel_y;
  assign polarity   = held_evt.polarity;
  assign event_time = held_evt.event_time;

  // framer position stays within the longest event
  `SEBD_ASSERT_NOW(a_pos_range, clk, rst, 1'b1, position <= POS_MAX,
    "byte position past last timestamp byte")

  // input only stalls with a byte held
  `SEBD_ASSERT_NOW(a_stall_full, clk, rst, byte_stall, q_valid,
    "byte stall without a captured byte")

  // a finishing byte always yields a pending event
  `SEBD_ASSERT_NEXT(a_fire_loads, clk, rst, step_en && step.fire, event_valid,
    "finished event not registered")

  // no event appears without a finishing byte
  `SEBD_ASSERT_NEXT(a_no_phantom, clk, rst, !event_valid && !(step_en && step.fire),
    !event_valid, "event appeared without a finishing byte")

endmodule

/* sv/sebd_in_stage.sv */
// input register for incoming link bytes
module sebd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] data_byte,
  input  logic       res_free,
  output logic       byte_stall,
  output logic       q_valid,
  output logic [7:0] q_byte
);
  import sebd_pkg::*;

  logic take;

  // hold while the loaded byte cannot move on
  assign byte_stall = q_valid && !res_free;
  assign take       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (take) begin
      q_valid <= 1'b1;
    end else if (res_free) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_byte <= data_byte;
    end
  end

endmodule

/* sv/sebd_frame_core.sv */
// framing state and per-byte event assembly
module sebd_frame_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  logic [7:0]          q_byte,
  input  sebd_pkg::mode_t     mode,
  output sebd_pkg::step_t     step,
  output sebd_pkg::pos_t      position
);
  import sebd_pkg::*;

  logic [6:0]  held_row;
  logic [7:0]  held_column_polarity;
  logic [31:0] time_accumulator;

  pos_t        position_next;
  logic [6:0]  held_row_next;
  logic [7:0]  held_column_polarity_next;
  logic [31:0] time_accumulator_next;

  pos_t        n_bytes;
  pos_t        last_pos;
  logic [31:0] acc_shift;

  assign n_bytes   = stamp_bytes(mode);
  assign last_pos  = n_bytes + 3'd1;
  assign acc_shift = {time_accumulator[23:0], q_byte};

  always_comb begin
    position_next             = position;
    held_row_next             = held_row;
    held_column_polarity_next = held_column_polarity;
    time_accumulator_next     = time_accumulator;
    step.fire                 = 1'b0;
    step.evt.pixel_x          = held_column_polarity[6:0];
    step.evt.pixel_y          = held_row;
    step.evt.polarity         = held_column_polarity[7];
    step.evt.event_time       = '0;
    case (position)
      POS_ROW: begin
        // only the row byte is checked for a clear high bit
        if (!q_byte[7]) begin
          held_row_next = q_byte[6:0];
          position_next = POS_COL;
        end
      end
      POS_COL: begin
        held_column_polarity_next = q_byte;
        time_accumulator_next     = '0;
        if (n_bytes == 3'd0) begin
          step.fire         = 1'b1;
          step.evt.pixel_x  = q_byte[6:0];
          step.evt.polarity = q_byte[7];
          position_next     = POS_ROW;
        end else begin
          position_next = POS_STAMP;
        end
      end
      default: begin
        time_accumulator_next = acc_shift;
        if (position >= last_pos) begin
          step.fire           = 1'b1;
          step.evt.event_time = (n_bytes == 3'd0) ? 32'd0 : acc_shift;
          position_next       = POS_ROW;
        end else begin
          position_next = position + 3'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= POS_ROW;
    end else if (step_en) begin
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      held_row             <= held_row_next;
      held_column_polarity <= held_column_polarity_next;
      time_accumulator     <= time_accumulator_next;
    end
  end

endmodule

/* sv/sebd_out_stage.sv */
// result register toward the event consumer
module sebd_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  sebd_pkg::event_t    evt,
  input  logic                event_stall,
  output logic                event_valid,
  output logic                res_free,
  output sebd_pkg::event_t    held_evt
);
  import sebd_pkg::*;

  // free when empty or emptying this cycle
  assign res_free = !event_valid || !event_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (load) begin
      event_valid <= 1'b1;
    end else if (res_free) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_evt <= evt;
    end
  end

endmodule
